// ----- design/pcm_pkg.sv -----
package pcm_pkg;

  typedef enum logic [1:0] {
    OP_CALL_ONE  = 2'd0,
    OP_CALL_EACH = 2'd1,
    OP_DRAIN     = 2'd2,
    OP_UNUSED    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_POSTED    = 3'd0,
    ST_LOCAL     = 3'd1,
    ST_NULL      = 3'd2,
    ST_BAD_TGT   = 3'd3,
    ST_FULL      = 3'd4,
    ST_BCAST     = 3'd5,
    ST_DELIVERED = 3'd6,
    ST_EMPTY     = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    REG_ONLINE_MASK  = 2'd0,
    REG_CPU_ID_LIMIT = 2'd1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_BCAST,
    S_DRAIN_RD,
    S_DRAIN_WAIT,
    S_OUT
  } state_t;

  localparam int MAX_RESULTS = 16;
  localparam int CFG_DATA_W  = 32;

  typedef struct packed {
    logic [1:0]  operation;
    logic [4:0]  requester_cpu;
    logic [5:0]  target_cpu;
    logic [63:0] func_handle;
    logic [63:0] func_arg;
    logic        wait_req;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        run_local;
    logic [31:0] ipi_mask;
    logic [5:0]  dispatched_count;
    logic [63:0] entry_handle;
    logic [63:0] entry_arg;
    logic        notify_needed;
    logic [4:0]  notify_cpu;
    logic        last;
  } out_item_t;

  // slot store write request
  typedef struct packed {
    logic        we;
    logic [63:0] handle;
    logic [63:0] arg;
    logic [5:0]  notify;
  } slot_wr_t;

endpackage

// ----- design/per_cpu_call_mailbox_rings.sv -----
// channel  | direction | handshake            | payload
// in_      | input     | in_valid / in_ready   | pcm_pkg::in_item_t
// out_     | output    | out_valid / out_ready | pcm_pkg::out_item_t
// cfg_     | input     | cfg_we                | cfg_index, cfg_data
//
// call_one checks a single ring; call_each walks the cpu ids below min(limit, cpu count),
// one cpu visited per cycle through the shared ring counter and compare
// drain: entries are read one at a time through the single slot memory read port
// reset is synchronous; ring counters clear at once, slot memory is not cleared
// one request at a time: in_ready drops until its last result is taken
// out_ stalls hold the result register and pause the sequencer
module per_cpu_call_mailbox_rings #(
  parameter int MAX_CPUS   = 32,
  parameter int RING_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pcm_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pcm_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import pcm_pkg::*;

  localparam int CPU_LIM = (MAX_CPUS < 32) ? MAX_CPUS : 32;
  localparam int CPU_W   = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int SLOT_W  = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int CNT_W   = SLOT_W + 1;
  // each ring gets a power-of-two region so slot bits index it directly
  localparam int DEPTH   = MAX_CPUS << SLOT_W;
  localparam int ADDR_W  = CPU_W + SLOT_W;

  // configuration
  logic [31:0] online_mask_r;
  logic [5:0]  cpu_id_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      online_mask_r  <= '0;
      cpu_id_limit_r <= 6'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ONLINE_MASK:  online_mask_r  <= cfg_data;
        REG_CPU_ID_LIMIT: cpu_id_limit_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // ring counters (one per cpu)
  logic [CNT_W-1:0] head_r [MAX_CPUS];
  logic [CNT_W-1:0] tail_r [MAX_CPUS];

  state_t      state_r, state_nxt;
  in_item_t    req_r, req_nxt;
  out_item_t   out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [5:0]  id_r, id_nxt;       // broadcast cursor, wide enough for 32
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic [4:0]  left_r, left_nxt;   // drain entries left

  // shared ring unit: one cpu per cycle
  logic [CPU_W-1:0] u_cpu;
  logic [CNT_W-1:0] u_fill;
  logic             u_full, u_empty;
  logic             head_inc, tail_inc;

  assign u_fill  = head_r[u_cpu] - tail_r[u_cpu];
  assign u_full  = (u_fill >= CNT_W'(RING_SLOTS));
  assign u_empty = (u_fill == '0);

  slot_wr_t          wr;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [133:0]      rd_data;

  assign wr.handle = req_r.func_handle;
  assign wr.arg    = req_r.func_arg;
  assign wr.notify = {req_r.wait_req, req_r.requester_cpu};
  assign wr.we     = head_inc;
  assign wr_addr   = {u_cpu, head_r[u_cpu][SLOT_W-1:0]};
  assign rd_addr   = {u_cpu, tail_r[u_cpu][SLOT_W-1:0]};

  pcm_slot_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_mem (
    .clk       (clk),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  // effective broadcast limit
  logic [5:0] lim;
  assign lim = (cpu_id_limit_r < 6'(CPU_LIM)) ? cpu_id_limit_r : 6'(CPU_LIM);

  function automatic logic is_online(input logic [31:0] m, input logic [5:0] id);
    logic ok;
    ok = (id < 6'(CPU_LIM)) && m[id[4:0]];
    return ok;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CPUS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else begin
      if (head_inc) head_r[u_cpu] <= head_r[u_cpu] + 1'b1;
      if (tail_inc) tail_r[u_cpu] <= tail_r[u_cpu] + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r  <= req_nxt;
    out_r  <= out_nxt;
    id_r   <= id_nxt;
    cnt_r  <= cnt_nxt;
    mask_r <= mask_nxt;
    left_r <= left_nxt;
  end

  always_comb begin
    logic [31:0] fill32;
    state_nxt     = state_r;
    req_nxt       = req_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    id_nxt        = id_r;
    cnt_nxt       = cnt_r;
    mask_nxt      = mask_r;
    left_nxt      = left_r;
    head_inc      = 1'b0;
    tail_inc      = 1'b0;
    u_cpu         = CPU_W'(req_r.requester_cpu);
    fill32        = 32'(u_fill);
    in_ready      = 1'b0;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt   = in_data;
          id_nxt    = '0;
          cnt_nxt   = 6'd1;
          mask_nxt  = '0;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        out_nxt      = '0;
        out_nxt.last = 1'b1;
        if (req_r.operation == OP_CALL_ONE) begin
          u_cpu = CPU_W'(req_r.target_cpu);
          if (req_r.func_handle == '0) begin
            out_nxt.status = ST_NULL;
          end else if (req_r.target_cpu == {1'b0, req_r.requester_cpu}) begin
            out_nxt.status    = ST_LOCAL;
            out_nxt.run_local = 1'b1;
          end else if (!is_online(online_mask_r, req_r.target_cpu)) begin
            out_nxt.status = ST_BAD_TGT;
          end else if (u_full) begin
            out_nxt.status = ST_FULL;
          end else begin
            head_inc       = 1'b1;
            out_nxt.status = ST_POSTED;
            out_nxt.ipi_mask = 32'd1 << req_r.target_cpu[4:0];
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else if (req_r.operation == OP_CALL_EACH) begin
          if (req_r.func_handle == '0) begin
            out_nxt.status = ST_NULL;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_OUT;
          end else begin
            state_nxt = S_BCAST;
          end
        end else if (req_r.operation == OP_DRAIN) begin
          if ({1'b0, req_r.requester_cpu} >= 6'(CPU_LIM) || u_empty) begin
            out_nxt.status = ST_EMPTY;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_OUT;
          end else begin
            left_nxt  = (fill32 > 32'(MAX_RESULTS)) ? 5'(MAX_RESULTS) : 5'(fill32);
            state_nxt = S_DRAIN_RD;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_BCAST: begin
        u_cpu = CPU_W'(id_r);
        if (id_r >= lim) begin
          out_nxt                  = '0;
          out_nxt.status           = ST_BCAST;
          out_nxt.run_local        = 1'b1;
          out_nxt.ipi_mask         = mask_r;
          out_nxt.dispatched_count = cnt_r;
          out_nxt.last             = 1'b1;
          out_valid_nxt            = 1'b1;
          state_nxt                = S_OUT;
        end else begin
          if (id_r != {1'b0, req_r.requester_cpu} && is_online(online_mask_r, id_r)
              && !u_full) begin
            head_inc = 1'b1;
            mask_nxt = mask_r | (32'd1 << id_r[4:0]);
            cnt_nxt  = cnt_r + 6'd1;
          end
          id_nxt = id_r + 6'd1;
        end
      end
      S_DRAIN_RD: begin
        // memory read issued on rd_addr, tail advances after read
        if (!out_valid_r || out_ready) begin
          tail_inc  = 1'b1;
          state_nxt = S_DRAIN_WAIT;
        end
      end
      S_DRAIN_WAIT: begin
        out_nxt               = '0;
        out_nxt.status        = ST_DELIVERED;
        out_nxt.entry_handle  = rd_data[133:70];
        out_nxt.entry_arg     = rd_data[69:6];
        out_nxt.notify_needed = rd_data[5];
        out_nxt.notify_cpu    = rd_data[4:0];
        out_nxt.last          = (left_r == 5'd1);
        out_valid_nxt         = 1'b1;
        left_nxt              = left_r - 5'd1;
        state_nxt             = (left_r == 5'd1) ? S_OUT : S_DRAIN_RD;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- design/pcm_slot_mem.sv -----
module pcm_slot_mem #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9
) (
  input  logic              clk,
  input  pcm_pkg::slot_wr_t wr,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [133:0]      rd_data_r
);
  import pcm_pkg::*;

  logic [133:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_r[wr_addr] <= {wr.handle, wr.arg, wr.notify};
    end
    rd_data_r <= mem_r[rd_addr];
  end

endmodule

// ----- design/pcm_checker.sv -----
module pcm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input pcm_pkg::out_item_t out_data
);
  import pcm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a waiting request stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("request withdrawn before it was taken");

  // no new request taken while a result is pending
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request accepted with result pending");

  // only a delivered entry can be non-final
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.status == ST_DELIVERED)
    else $error("non-final result not a delivery");

  // run_local only on local or broadcast results
  a_local: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.run_local |->
      out_data.status == ST_LOCAL || out_data.status == ST_BCAST)
    else $error("bad run_local");

endmodule

bind per_cpu_call_mailbox_rings pcm_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- tb/per_cpu_call_mailbox_rings_tb.sv -----
module per_cpu_call_mailbox_rings_tb;
  import pcm_pkg::*;

  // mailbox predictor and store of pending results
  class mailbox_scoreboard;
    logic [31:0] online_mask;
    logic [5:0]  cpu_id_limit;
    logic [4:0]  head [32];
    logic [4:0]  tail [32];
    logic [63:0] slot_handle [512];
    logic [63:0] slot_arg [512];
    logic [5:0]  slot_notify [512];
    out_item_t   pending [$];

    function new();
      online_mask  = '0;
      cpu_id_limit = 6'd32;
      foreach (head[i]) begin
        head[i] = '0;
        tail[i] = '0;
      end
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      if (idx == REG_ONLINE_MASK) online_mask = val;
      else if (idx == REG_CPU_ID_LIMIT) cpu_id_limit = val[5:0];
    endfunction

    function bit is_online(logic [5:0] id);
      return id < 32 && online_mask[id[4:0]];
    endfunction

    // counters wrap at twice the ring size, which is exactly 5 bits
    function bit post(logic [4:0] cpu, in_item_t r);
      logic [4:0] fill;
      int         idx;
      fill = head[cpu] - tail[cpu];
      if (fill >= 16) return 0;
      idx = cpu * 16 + head[cpu][3:0];
      slot_handle[idx] = r.func_handle;
      slot_arg[idx]    = r.func_arg;
      slot_notify[idx] = {r.wait_req, r.requester_cpu};
      head[cpu]        = head[cpu] + 5'd1;
      return 1;
    endfunction

    function void note_request(in_item_t r);
      out_item_t  e;
      int         lim;
      int         n;
      int         idx;
      logic [4:0] fill;
      e = '0;
      e.last = 1'b1;
      case (op_t'(r.operation))
        OP_CALL_ONE: begin
          if (r.func_handle == 0) e.status = ST_NULL;
          else if (r.target_cpu == {1'b0, r.requester_cpu}) begin
            e.status    = ST_LOCAL;
            e.run_local = 1'b1;
          end else if (!is_online(r.target_cpu)) e.status = ST_BAD_TGT;
          else if (!post(r.target_cpu[4:0], r)) e.status = ST_FULL;
          else begin
            e.status   = ST_POSTED;
            e.ipi_mask = 32'd1 << r.target_cpu[4:0];
          end
          pending.push_back(e);
        end
        OP_CALL_EACH: begin
          if (r.func_handle == 0) e.status = ST_NULL;
          else begin
            lim = (cpu_id_limit < 32) ? cpu_id_limit : 32;
            e.status           = ST_BCAST;
            e.run_local        = 1'b1;
            e.dispatched_count = 6'd1;
            for (int id = 0; id < lim; id++) begin
              if (id != r.requester_cpu && online_mask[id] && post(id[4:0], r)) begin
                e.ipi_mask[id]     = 1'b1;
                e.dispatched_count = e.dispatched_count + 6'd1;
              end
            end
          end
          pending.push_back(e);
        end
        OP_DRAIN: begin
          fill = head[r.requester_cpu] - tail[r.requester_cpu];
          if (fill == 0) begin
            e.status = ST_EMPTY;
            pending.push_back(e);
          end else begin
            n = (fill > MAX_RESULTS) ? MAX_RESULTS : fill;
            for (int k = 0; k < n; k++) begin
              idx = r.requester_cpu * 16 + tail[r.requester_cpu][3:0];
              e = '0;
              e.status        = ST_DELIVERED;
              e.entry_handle  = slot_handle[idx];
              e.entry_arg     = slot_arg[idx];
              e.notify_needed = slot_notify[idx][5];
              e.notify_cpu    = slot_notify[idx][4:0];
              e.last          = (k == n - 1);
              pending.push_back(e);
              tail[r.requester_cpu] = tail[r.requester_cpu] + 5'd1;
            end
          end
        end
        default: ;
      endcase
    endfunction

    // returns a message naming the wrong fields (or unexpected result when none is pending), empty when it matches
    function string check_result(out_item_t got);
      out_item_t e;
      string     bad;
      bad = "";
      if (pending.size() == 0) return "unexpected result";
      e = pending.pop_front();
      if (got.status !== e.status) bad = {bad, " status"};
      if (got.run_local !== e.run_local) bad = {bad, " run_local"};
      if (got.ipi_mask !== e.ipi_mask) bad = {bad, " ipi_mask"};
      if (got.dispatched_count !== e.dispatched_count) bad = {bad, " dispatched_count"};
      if (got.entry_handle !== e.entry_handle) bad = {bad, " entry_handle"};
      if (got.entry_arg !== e.entry_arg) bad = {bad, " entry_arg"};
      if (got.notify_needed !== e.notify_needed) bad = {bad, " notify_needed"};
      if (got.notify_cpu !== e.notify_cpu) bad = {bad, " notify_cpu"};
      if (got.last !== e.last) bad = {bad, " last"};
      if (bad != "") bad = $sformatf("wrong%s: got %h want %h", bad, got, e);
      return bad;
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  mailbox_scoreboard sb;
  int  n_errors;
  int  n_requests;
  int  n_results;
  int  n_delivered;
  int  n_full;
  bit  quiet;   // no idling on either side while set

  per_cpu_call_mailbox_rings dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    n_errors++;
  endtask

  // result side: random back-pressure, check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      string msg;
      msg = sb.check_result(out_data);
      n_results++;
      if (out_data.status == ST_DELIVERED) n_delivered++;
      if (out_data.status == ST_FULL) n_full++;
      if (msg != "") report(msg);
    end
    out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 11);
  end

  // only written while nothing is in flight
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // holds the request until taken, then maybe a random gap
  task automatic send_req(in_item_t r);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_request(r);
    n_requests++;
    if (!quiet && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_fields(op_t op, logic [4:0] req, logic [5:0] tgt,
                             logic [63:0] h, logic [63:0] a, logic w);
    in_item_t r;
    r.operation     = op;
    r.requester_cpu = req;
    r.target_cpu    = tgt;
    r.func_handle   = h;
    r.func_arg      = a;
    r.wait_req      = w;
    send_req(r);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly well-formed calls and drains, with some noise
  task automatic random_phase(int count);
    in_item_t r;
    int       pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      r.requester_cpu = 5'($urandom);
      r.target_cpu    = 6'($urandom_range(31));
      r.func_handle   = rand64();
      r.func_arg      = rand64();
      r.wait_req      = 1'($urandom);
      if (pick < 45) r.operation = OP_CALL_ONE;
      else if (pick < 60) r.operation = OP_CALL_EACH;
      else if (pick < 90) r.operation = OP_DRAIN;
      else begin
        // noise: unused code, null handle, target beyond range
        r.operation = 2'($urandom);
        if ($urandom_range(1)) r.func_handle = 0;
        r.target_cpu = 6'($urandom);
      end
      send_req(r);
    end
  endtask

  initial begin
    #3_000_000;
    $display("timeout waiting for results");
    $display("status: fail");
    $finish;
  end

  initial begin
    sb = new();
    n_errors = 0;
    n_requests = 0;
    n_results = 0;
    n_delivered = 0;
    n_full = 0;
    quiet = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset config has every cpu offline
    send_fields(OP_CALL_ONE, 5'd3, 6'd4, 64'd1, '1, 1'b1);       // offline target
    send_fields(OP_CALL_ONE, 5'd5, 6'd5, '1, 64'd7, 1'b0);       // call to self
    send_fields(OP_CALL_ONE, 5'd0, 6'd1, 64'd0, 64'd9, 1'b1);    // null handle
    send_fields(OP_CALL_EACH, 5'd0, 6'd0, 64'd0, 64'd0, 1'b0);   // null broadcast
    send_fields(OP_CALL_EACH, 5'd2, 6'd0, 64'd5, 64'd6, 1'b1);   // nobody online
    send_fields(OP_DRAIN, 5'd31, 6'd0, 64'd0, 64'd0, 1'b0);      // empty mailbox
    send_fields(OP_UNUSED, 5'd1, 6'd2, 64'd3, 64'd4, 1'b1);      // ignored

    write_reg(REG_ONLINE_MASK, 32'hFFFF_FFFF);
    send_fields(OP_CALL_ONE, 5'd0, 6'd63, '1, '1, 1'b1);         // target out of range
    send_fields(OP_CALL_ONE, 5'd31, 6'd32, 64'd1, 64'd1, 1'b0);
    send_fields(OP_CALL_ONE, 5'd0, 6'd31, '1, '1, 1'b1);
    // fill ring 7 past capacity, then drain it whole
    for (int i = 0; i < 17; i++)
      send_fields(OP_CALL_ONE, i[4:0] + 5'd8, 6'd7, rand64() | 64'd1, rand64(), i[0]);
    send_fields(OP_DRAIN, 5'd7, 6'd0, 64'd0, 64'd0, 1'b0);
    send_fields(OP_CALL_EACH, 5'd31, 6'd0, '1, 64'h0123_4567_89AB_CDEF, 1'b1);
    send_fields(OP_DRAIN, 5'd31, 6'd0, 64'd0, 64'd0, 1'b0);

    // broadcast limit of zero, then a limit beyond the cpu count
    write_reg(REG_CPU_ID_LIMIT, 32'd0);
    send_fields(OP_CALL_EACH, 5'd1, 6'd0, 64'd2, 64'd3, 1'b0);
    write_reg(REG_CPU_ID_LIMIT, 32'd63);
    quiet = 1'b1;
    random_phase(50);
    quiet = 1'b0;

    // few cpus online so that rings fill and skips happen
    write_reg(REG_ONLINE_MASK, 32'h8000_0013);
    write_reg(REG_CPU_ID_LIMIT, 32'd32);
    random_phase(50);

    write_reg(REG_ONLINE_MASK, $urandom);
    write_reg(REG_CPU_ID_LIMIT, $urandom_range(1, 31));
    random_phase(45);

    write_reg(REG_ONLINE_MASK, 32'd0);
    random_phase(15);
    write_reg(REG_ONLINE_MASK, 32'hFFFF_FFFF);
    write_reg(REG_CPU_ID_LIMIT, 32'd32);
    random_phase(20);
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d requests and %0d results across several register settings",
             n_requests, n_results);
    $display("%0d entries delivered by drains, %0d calls refused on a full ring",
             n_delivered, n_full);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/pcm_pkg.sv
design/pcm_slot_mem.sv
design/per_cpu_call_mailbox_rings.sv
design/pcm_checker.sv
tb/per_cpu_call_mailbox_rings_tb.sv
